@@ sv/afs_pkg.sv @@
// Package for the animation frame selector: widths, register and mode codes,
// and the per-stage divide/modulo step used by the pipelined divider.
// No dependencies.
package afs_pkg;

    // Time word and divider geometry
    localparam int TIME_BITS      = 32;
    localparam int ELAPSED_W      = 32;
    localparam int BITS_PER_STAGE = 2;
    localparam int DIV_STAGES     = (TIME_BITS + BITS_PER_STAGE - 1) / BITS_PER_STAGE;
    localparam int DIV_BITS       = DIV_STAGES * BITS_PER_STAGE;

    // Field widths
    localparam int COUNT_W     = 8;
    localparam int PERIOD_W    = 16;
    localparam int MODE_W      = 2;
    localparam int INTENSITY_W = 8;
    localparam int FRAME_W     = 8;
    localparam int MOD_W       = COUNT_W + 1;
    localparam int PROD_W      = FRAME_W + INTENSITY_W;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;

    // Divide by the full-swing constant through a reciprocal multiply:
    // exact for products below 2**PROD_W
    localparam int FULL_SWING  = 120;
    localparam int RECIP_SHIFT = PROD_W + 7;
    localparam int RECIP_W     = 17;
    localparam logic [RECIP_W-1:0] RECIP_K =
        RECIP_W'(((64'd1 << RECIP_SHIFT) + FULL_SWING - 1) / FULL_SWING);
    localparam int SCALED_W    = PROD_W + RECIP_W;

    // Post-divider stages: level, product, scale, clip/output
    localparam int LATENCY = DIV_STAGES + 4;

    // Reset values
    localparam logic [COUNT_W-1:0]     RST_COUNT     = COUNT_W'(1);
    localparam logic [PERIOD_W-1:0]    RST_PERIOD    = PERIOD_W'(100);
    localparam logic [INTENSITY_W-1:0] RST_INTENSITY = INTENSITY_W'(FULL_SWING);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FRAME_COUNT     = 2'd0,
        REG_FRAME_PERIOD    = 2'd1,
        REG_PLAYBACK_MODE   = 2'd2,
        REG_MOUTH_INTENSITY = 2'd3
    } t_cfg_reg;

    typedef enum logic [MODE_W-1:0] {
        MODE_LOOP      = 2'd0,
        MODE_PINGPONG  = 2'd1,
        MODE_INTENSITY = 2'd2,
        MODE_LOOP_ALT  = 2'd3
    } t_mode;

    // One divider stage: running remainder by the period, the remaining
    // dividend bits, and the quotient taken modulo the frame modulus
    typedef struct packed {
        logic [PERIOD_W-1:0] rem;
        logic [DIV_BITS-1:0] dvd;
        logic [MOD_W-1:0]    modr;
    } t_div_state;

    function automatic logic is_bounce(t_mode mode);
        return (mode == MODE_PINGPONG) || (mode == MODE_INTENSITY);
    endfunction

    // Modulus applied to the step count: frame count for loop, twice the
    // last frame for the bouncing modes, one for a short animation
    function automatic logic [MOD_W-1:0] frame_modulus(logic [COUNT_W-1:0] count,
                                                       t_mode mode);
        logic [COUNT_W-1:0] last;
        last = count - COUNT_W'(1);
        if (count <= COUNT_W'(1)) begin
            return MOD_W'(1);
        end else if (is_bounce(mode)) begin
            return {last, 1'b0};
        end else begin
            return {1'b0, count};
        end
    endfunction

    // Restoring divide, BITS_PER_STAGE quotient bits; each quotient bit also
    // folds into the running modulo
    function automatic t_div_state div_step(t_div_state s, logic [PERIOD_W-1:0] p,
                                            logic [MOD_W-1:0] m);
        t_div_state      o;
        logic [PERIOD_W:0] t;
        logic [MOD_W:0]    u;
        logic              q;
        o = s;
        for (int k = 0; k < BITS_PER_STAGE; k++) begin
            t     = {o.rem, o.dvd[DIV_BITS-1]};
            o.dvd = {o.dvd[DIV_BITS-2:0], 1'b0};
            q     = (t >= {1'b0, p});
            if (q) begin
                t = t - {1'b0, p};
            end
            o.rem = t[PERIOD_W-1:0];
            u     = {o.modr, q};
            if (u >= {1'b0, m}) begin
                u = u - {1'b0, m};
            end
            o.modr = u[MOD_W-1:0];
        end
        return o;
    endfunction

endpackage

@@ sv/animation_frame_selector_core.sv @@
// Animation frame selector top level: configuration registers, pipelined
// time divider with running modulo, bounce, intensity scale and clip.
// Depends on afs_pkg.
//
// Usage:
//   Input: drive i_elapsed_ms and pulse start; a transaction is taken at each
//   rising edge with start high and busy low. busy is always low, so one
//   transaction can be issued every cycle.
//   Output: o_result_valid is high for one cycle with o_frame_index; the
//   receiver cannot stall and every result is taken in that cycle.
//   Pipeline: the divider resolves two quotient bits per stage, which sets
//   the stage count; then a bounce stage, an intensity multiply, a
//   reciprocal divide by 120 and a clip/output stage follow.
//   Throughput: one transaction per cycle, sustained.
//   Configuration: i_cfg_we writes i_cfg_data into register i_cfg_index at
//   the clock edge; write only while no transaction is in flight.
//   Reset: synchronous, active low; empties the pipeline and restores the
//   register defaults (count 1, period 100, loop mode, intensity 120).
module animation_frame_selector_core
    import afs_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [ELAPSED_W-1:0]  i_elapsed_ms,
    output logic                  o_result_valid,
    output logic [FRAME_W-1:0]    o_frame_index,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    // Configuration and derived values
    logic [COUNT_W-1:0]     r_count;
    logic [PERIOD_W-1:0]    r_period_eff;
    t_mode                  r_mode;
    logic [INTENSITY_W-1:0] r_intensity;
    logic [MOD_W-1:0]       r_modulus;

    logic [COUNT_W-1:0]     n_count;
    t_mode                  n_mode;
    logic [COUNT_W-1:0]     last;

    // Pipeline stages
    logic                   r_div_valid [DIV_STAGES];
    t_div_state             r_div       [DIV_STAGES];
    logic                   r_lvl_valid;
    logic [FRAME_W-1:0]     r_level;
    logic                   r_prod_valid;
    logic [PROD_W-1:0]      r_prod;
    logic                   r_scl_valid;
    logic [SCALED_W-1:0]    r_scaled;

    logic                   accept;
    t_div_state             div_in;
    logic [MOD_W-1:0]       phase;
    logic [MOD_W-1:0]       mirror;
    logic [FRAME_W-1:0]     n_level;
    logic [PROD_W-1:0]      n_prod;
    logic [SCALED_W-1:0]    n_scaled;
    logic [SCALED_W-1:0]    quotient;
    logic [FRAME_W-1:0]     n_frame;

    // The pipeline takes a transaction every cycle
    assign busy   = 1'b0;
    assign accept = start && !busy;
    assign last   = r_count - COUNT_W'(1);

    // Next values of count and mode so the modulus follows a write at once
    always_comb begin
        n_count = r_count;
        n_mode  = r_mode;
        if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_index))
                REG_FRAME_COUNT:     n_count = i_cfg_data[COUNT_W-1:0];
                REG_PLAYBACK_MODE:   n_mode  = t_mode'(i_cfg_data[MODE_W-1:0]);
                REG_FRAME_PERIOD:    ;
                REG_MOUTH_INTENSITY: ;
            endcase
        end
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count      <= RST_COUNT;
            r_period_eff <= RST_PERIOD;
            r_mode       <= MODE_LOOP;
            r_intensity  <= RST_INTENSITY;
            r_modulus    <= frame_modulus(RST_COUNT, MODE_LOOP);
        end else begin
            r_count   <= n_count;
            r_mode    <= n_mode;
            r_modulus <= frame_modulus(n_count, n_mode);
            if (i_cfg_we && t_cfg_reg'(i_cfg_index) == REG_FRAME_PERIOD) begin
                // a zero period is held at one
                r_period_eff <= (i_cfg_data[PERIOD_W-1:0] == '0) ?
                                PERIOD_W'(1) : i_cfg_data[PERIOD_W-1:0];
            end
            if (i_cfg_we && t_cfg_reg'(i_cfg_index) == REG_MOUTH_INTENSITY) begin
                r_intensity <= i_cfg_data[INTENSITY_W-1:0];
            end
        end
    end

    // Divider entry: only the low TIME_BITS bits of the time count
    always_comb begin
        div_in.rem  = '0;
        div_in.dvd  = DIV_BITS'(i_elapsed_ms[TIME_BITS-1:0]);
        div_in.modr = '0;
    end

    // Divider stage 0
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div_valid[0] <= 1'b0;
        end else begin
            r_div_valid[0] <= accept;
        end
        r_div[0] <= div_step(div_in, r_period_eff, r_modulus);
    end

    // Remaining divider stages
    for (genvar s = 1; s < DIV_STAGES; s++) begin : g_div
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_div_valid[s] <= 1'b0;
            end else begin
                r_div_valid[s] <= r_div_valid[s-1];
            end
            r_div[s] <= div_step(r_div[s-1], r_period_eff, r_modulus);
        end
    end

    // Bounce: fold the phase back past the last frame
    always_comb begin
        phase  = r_div[DIV_STAGES-1].modr;
        mirror = r_modulus - phase;
        if (r_count <= COUNT_W'(1)) begin
            n_level = '0;
        end else if (is_bounce(r_mode) && phase > {1'b0, last}) begin
            n_level = mirror[FRAME_W-1:0];
        end else begin
            n_level = phase[FRAME_W-1:0];
        end
    end

    // Intensity multiply, reciprocal divide and clip in intensity mode; other modes pass the level through
    always_comb begin
        if (r_mode == MODE_INTENSITY) begin
            n_prod = PROD_W'(r_level) * PROD_W'(r_intensity);
        end else begin
            n_prod = PROD_W'(r_level);
        end
        n_scaled = SCALED_W'(r_prod) * SCALED_W'(RECIP_K);
        quotient = r_scaled >> RECIP_SHIFT;
        if (r_mode == MODE_INTENSITY) begin
            n_frame = (quotient < SCALED_W'(last)) ? quotient[FRAME_W-1:0] : last;
        end else begin
            n_frame = r_scaled[FRAME_W-1:0];
        end
    end

    // Back-end stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lvl_valid    <= 1'b0;
            r_prod_valid   <= 1'b0;
            r_scl_valid    <= 1'b0;
            o_result_valid <= 1'b0;
        end else begin
            r_lvl_valid    <= r_div_valid[DIV_STAGES-1];
            r_prod_valid   <= r_lvl_valid;
            r_scl_valid    <= r_prod_valid;
            o_result_valid <= r_scl_valid;
        end
        r_level       <= n_level;
        r_prod        <= n_prod;
        // the scale stage passes the product on when no scaling applies
        r_scaled      <= (r_mode == MODE_INTENSITY) ? n_scaled : SCALED_W'(r_prod);
        o_frame_index <= n_frame;
    end

`ifndef SYNTHESIS
    // An accepted transaction enters the divider
    a_enter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_div_valid[0])
        else $error("accepted transaction missing from divider entry");

    // A divider result reaches the output after the back-end stages
    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_div_valid[DIV_STAGES-1] |-> ##4 o_result_valid)
        else $error("divider result lost in back end");

    // Every result comes from an accepted transaction
    a_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> $past(accept, LATENCY))
        else $error("result without matching transaction");
`endif

endmodule
